@@ rtl/core/rbts_pkg.sv @@
// ----------------------------------------------------------------------------
// rbts_pkg
// Shared types and constants for the rolling band trade signal unit.
// ----------------------------------------------------------------------------
package rbts_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int WLEN_W     = 7;
    localparam int TIME_W     = 48;
    localparam int PRICE_W    = 24;
    localparam int SUM_W      = 30;
    localparam int SQSUM_W    = 54;
    localparam int KW_W       = 16;
    localparam int CAP_W      = 40;
    localparam int QTY_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [WLEN_W-1:0] WLEN_MIN   = WLEN_W'(2);
    localparam logic [WLEN_W-1:0] WLEN_MAX   = WLEN_W'(MAX_WINDOW);
    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(20);
    localparam logic [KW_W-1:0]   KW_RESET   = KW_W'(8192);

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPITAL       = 2'd2;

    localparam logic EVT_OPEN  = 1'b0;
    localparam logic EVT_CLOSE = 1'b1;

    typedef struct packed {
        logic [WLEN_W-1:0] window_length;
        logic [KW_W-1:0]   band_width;
        logic [CAP_W-1:0]  capital;
    } cfg_t;

    // One primed tick with the window statistics that include it.
    typedef struct packed {
        logic [TIME_W-1:0]  tick_time;
        logic [PRICE_W-1:0] close_price;
        logic [PRICE_W-1:0] buy_price;
        logic [PRICE_W-1:0] sell_price;
        logic [SUM_W-1:0]   window_sum;
        logic [SQSUM_W-1:0] square_sum;
        logic [WLEN_W-1:0]  window_length;
    } tick_entry_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SQR,
        F_UPD,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIFF,
        B_PLO,
        B_PHI,
        B_CMP,
        B_DIV
    } back_state_t;

endpackage

@@ rtl/core/rbts_front.sv @@
// ----------------------------------------------------------------------------
// rbts_front
// Accepts ticks, keeps the close ring and the running sums, queues primed ticks.
// ----------------------------------------------------------------------------
module rbts_front
    import rbts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [WLEN_W-1:0]   window_length,
    input  logic                restart,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [TIME_W-1:0]   tick_time,
    input  logic [PRICE_W-1:0]  close_price,
    input  logic [PRICE_W-1:0]  buy_price,
    input  logic [PRICE_W-1:0]  sell_price,
    output logic                push,
    output tick_entry_t         push_entry,
    input  logic                queue_full
);

    front_state_t state_reg, state_next;

    logic [PTR_W-1:0]   ptr_reg;
    logic [WLEN_W-1:0]  seen_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SQSUM_W-1:0] sq_reg;

    logic [TIME_W-1:0]    time_reg;
    logic [PRICE_W-1:0]   close_reg;
    logic [PRICE_W-1:0]   buy_reg;
    logic [PRICE_W-1:0]   sell_reg;
    logic                 primed_reg;
    logic [PRICE_W-1:0]   old_reg;
    logic [2*PRICE_W-1:0] csq_reg;
    logic [2*PRICE_W-1:0] osq_reg;

    logic [PRICE_W-1:0] ring_mem [MAX_WINDOW];

    logic               accept;
    logic               primed;
    logic [PTR_W:0]     rd_sum;
    logic [PTR_W-1:0]   rd_idx;
    logic [PTR_W-1:0]   ptr_inc;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != F_IDLE);
    assign primed   = (seen_reg >= window_length);

    // Oldest entry sits window_length slots behind the write pointer.
    always_comb
    begin
        rd_sum = {1'b0, ptr_reg} + (PTR_W+1)'(WLEN_W'(MAX_WINDOW) - window_length);
        if (rd_sum >= (PTR_W+1)'(MAX_WINDOW))
        begin
            rd_idx = PTR_W'(rd_sum - (PTR_W+1)'(MAX_WINDOW));
        end
        else
        begin
            rd_idx = rd_sum[PTR_W-1:0];
        end
        ptr_inc = (ptr_reg == PTR_W'(MAX_WINDOW-1)) ? '0 : ptr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_UPD)
        begin
            ring_mem[ptr_reg] <= close_reg;
        end
        if (accept)
        begin
            old_reg <= ring_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            time_reg   <= tick_time;
            close_reg  <= close_price;
            buy_reg    <= buy_price;
            sell_reg   <= sell_price;
            primed_reg <= primed;
            csq_reg    <= close_price * close_price;
        end
        if (state_reg == F_SQR)
        begin
            osq_reg <= primed_reg ? old_reg * old_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            ptr_reg   <= '0;
            seen_reg  <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (restart)
            begin
                ptr_reg  <= '0;
                seen_reg <= '0;
                sum_reg  <= '0;
                sq_reg   <= '0;
            end
            else if (state_reg == F_UPD)
            begin
                ptr_reg <= ptr_inc;
                if (!primed_reg)
                begin
                    seen_reg <= seen_reg + 1'b1;
                end
                sum_reg <= sum_reg - (primed_reg ? SUM_W'(old_reg) : '0)
                           + SUM_W'(close_reg);
                sq_reg  <= sq_reg - SQSUM_W'(osq_reg) + SQSUM_W'(csq_reg);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_SQR;
                end
            end
            F_SQR:
            begin
                state_next = F_UPD;
            end
            F_UPD:
            begin
                state_next = primed_reg ? F_PUSH : F_IDLE;
            end
            F_PUSH:
            begin
                if (!queue_full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign push_entry.tick_time     = time_reg;
    assign push_entry.close_price   = close_reg;
    assign push_entry.buy_price     = buy_reg;
    assign push_entry.sell_price    = sell_reg;
    assign push_entry.window_sum    = sum_reg;
    assign push_entry.square_sum    = sq_reg;
    assign push_entry.window_length = window_length;

endmodule

@@ rtl/core/rbts_queue.sv @@
// ----------------------------------------------------------------------------
// rbts_queue
// Short FIFO of primed ticks between front and back.
// ----------------------------------------------------------------------------
module rbts_queue
    import rbts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  tick_entry_t push_entry,
    input  logic        pop,
    output tick_entry_t pop_entry,
    output logic        full,
    output logic        empty
);

    tick_entry_t slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QPTR_W:0]   count_reg;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

endmodule

@@ rtl/core/rbts_back.sv @@
// ----------------------------------------------------------------------------
// rbts_back
// Band test, position tracking, quantity divider and the result register.
// ----------------------------------------------------------------------------
module rbts_back
    import rbts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                queue_empty,
    input  tick_entry_t         pop_entry,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                event_kind,
    output logic [TIME_W-1:0]   event_time,
    output logic [PRICE_W-1:0]  event_price,
    output logic [QTY_W-1:0]    trade_quantity
);

    localparam int NQ_W   = WLEN_W + SQSUM_W;   // 61
    localparam int NC_W   = WLEN_W + PRICE_W;   // 31
    localparam int DIF_W  = SUM_W + 1;          // 31
    localparam int K2_W   = 2 * KW_W;           // 32
    localparam int LO_W   = 31;
    localparam int HI_W   = NQ_W - LO_W;        // 30
    localparam int CMP_W  = 94;
    localparam int DVS_W  = PRICE_W + 5;        // 20 * buy
    localparam int REM_W  = DVS_W + 1;
    localparam int CNT_W  = 6;

    back_state_t state_reg, state_next;

    tick_entry_t           e_reg;
    logic [NQ_W-1:0]       nq_reg;
    logic [2*SUM_W-1:0]    ss_reg;
    logic [NC_W-1:0]       nc_reg;
    logic [K2_W-1:0]       k2_reg;
    logic [NQ_W-1:0]       d_reg;
    logic [DIF_W-1:0]      dif_reg;
    logic                  dpos_reg;
    logic [2*DIF_W-1:0]    dsq_reg;
    logic [LO_W+K2_W-1:0]  plo_reg;
    logic [HI_W+K2_W-1:0]  phi_reg;
    logic                  holding_reg;

    logic [CAP_W-1:0]      dvd_reg;
    logic [CAP_W-1:0]      quo_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [DVS_W-1:0]      dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic                  out_valid_reg;
    logic                  kind_reg;
    logic [TIME_W-1:0]     time_reg;
    logic [PRICE_W-1:0]    price_reg;
    logic [QTY_W-1:0]      qty_reg;

    logic [CMP_W-1:0]      rhs;
    logic [CMP_W-1:0]      lhs;
    logic                  hit;
    logic [REM_W-1:0]      rem_shift;
    logic                  rem_ge;
    logic [CAP_W-1:0]      quo_next;
    logic [QTY_W-1:0]      qty_sat;
    logic                  load_open;
    logic                  load_close;
    logic                  div_start;
    logic                  div_done;

    assign rhs = (CMP_W'(phi_reg) << LO_W) + CMP_W'(plo_reg);
    assign lhs = CMP_W'(dsq_reg) << 24;
    assign hit = dpos_reg && (lhs > rhs);

    assign rem_shift = {rem_reg[REM_W-2:0], dvd_reg[CAP_W-1]};
    assign rem_ge    = (rem_shift >= REM_W'(dvs_reg));
    assign quo_next  = {quo_reg[CAP_W-2:0], rem_ge};
    assign qty_sat   = (quo_next[CAP_W-1:QTY_W] != '0) ? '1 : quo_next[QTY_W-1:0];
    assign div_done  = (state_reg == B_DIV) && (cnt_reg == CNT_W'(CAP_W-1));

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_open  = 1'b0;
        load_close = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!queue_empty && !out_valid_reg)
                begin
                    pop        = 1'b1;
                    state_next = B_MUL;
                end
            end
            B_MUL:  state_next = B_DIFF;
            B_DIFF: state_next = B_PLO;
            B_PLO:  state_next = B_PHI;
            B_PHI:  state_next = B_CMP;
            B_CMP:
            begin
                state_next = B_IDLE;
                if (hit)
                begin
                    if (holding_reg)
                    begin
                        load_close = 1'b1;
                    end
                    else if (e_reg.buy_price == '0)
                    begin
                        load_open = 1'b1;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = B_DIV;
                    end
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    load_open  = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Datapath, one multiplier stage per cycle.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e_reg <= pop_entry;
        end
        if (state_reg == B_MUL)
        begin
            nq_reg <= e_reg.window_length * e_reg.square_sum;
            ss_reg <= e_reg.window_sum * e_reg.window_sum;
            nc_reg <= e_reg.window_length * e_reg.close_price;
            k2_reg <= cfg.band_width * cfg.band_width;
        end
        if (state_reg == B_DIFF)
        begin
            d_reg <= nq_reg - NQ_W'(ss_reg);
            if (holding_reg)
            begin
                dpos_reg <= (NC_W'(e_reg.window_sum) < nc_reg);
                dif_reg  <= DIF_W'(nc_reg - NC_W'(e_reg.window_sum));
            end
            else
            begin
                dpos_reg <= (NC_W'(e_reg.window_sum) > nc_reg);
                dif_reg  <= DIF_W'(NC_W'(e_reg.window_sum) - nc_reg);
            end
        end
        if (state_reg == B_PLO)
        begin
            plo_reg <= d_reg[LO_W-1:0] * k2_reg;
            dsq_reg <= dif_reg * dif_reg;
        end
        if (state_reg == B_PHI)
        begin
            phi_reg <= d_reg[NQ_W-1:LO_W] * k2_reg;
        end
        if (div_start)
        begin
            dvd_reg <= cfg.capital;
            quo_reg <= '0;
            rem_reg <= '0;
            dvs_reg <= DVS_W'(e_reg.buy_price) * DVS_W'(20);
        end
        else if (state_reg == B_DIV)
        begin
            dvd_reg <= {dvd_reg[CAP_W-2:0], 1'b0};
            quo_reg <= quo_next;
            rem_reg <= rem_ge ? rem_shift - REM_W'(dvs_reg) : rem_shift;
        end
        if (load_open)
        begin
            kind_reg  <= EVT_OPEN;
            time_reg  <= e_reg.tick_time;
            price_reg <= e_reg.buy_price;
            qty_reg   <= (state_reg == B_DIV) ? qty_sat : '0;
        end
        else if (load_close)
        begin
            kind_reg  <= EVT_CLOSE;
            time_reg  <= e_reg.tick_time;
            price_reg <= e_reg.sell_price;
            qty_reg   <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            holding_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_open)
            begin
                holding_reg <= 1'b1;
            end
            else if (load_close)
            begin
                holding_reg <= 1'b0;
            end
            if (load_open || load_close)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (div_start)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == B_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = kind_reg;
    assign event_time     = time_reg;
    assign event_price    = price_reg;
    assign trade_quantity = qty_reg;

endmodule

@@ rtl/core/rolling_band_trade_signal_unit.sv @@
// ----------------------------------------------------------------------------
// rolling_band_trade_signal_unit
// Band-based mean-reversion signal over a moving window of close prices.
// ----------------------------------------------------------------------------
// Flow: the front takes one tick at a time (idle, square, update, push; no
//   push in warm-up); with no event, the back's pop and five-step band test
//   set the pace. Closes and zero-price opens load the result straight from
//   the band test; other opens first run the bit-serial quantity divider.
// A waiting event holds the back until taken; the two-entry queue then fills.
// Reset: asynchronous active low; no clearing pass for the close ring.
// ----------------------------------------------------------------------------
module rolling_band_trade_signal_unit
    import rbts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CAP_W-1:0]      cfg_data,
    // tick input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TIME_W-1:0]     tick_time,
    input  logic [PRICE_W-1:0]    close_price,
    input  logic [PRICE_W-1:0]    buy_price,
    input  logic [PRICE_W-1:0]    sell_price,
    // event output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  event_kind,
    output logic [TIME_W-1:0]     event_time,
    output logic [PRICE_W-1:0]    event_price,
    output logic [QTY_W-1:0]      trade_quantity
);

    cfg_t              cfg_reg;
    logic              cfg_wr;
    logic              restart;
    logic [WLEN_W-1:0] wlen_raw;
    logic [WLEN_W-1:0] wlen_clamped;

    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    tick_entry_t push_entry;
    tick_entry_t pop_entry;

    // Config writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    // Any window length write restarts the window; position is kept.
    assign restart   = cfg_wr && (cfg_index == CFG_WINDOW_LENGTH);

    // Window length is clamped into [2, MAX_WINDOW] before it is stored.
    assign wlen_raw = cfg_data[WLEN_W-1:0];
    always_comb
    begin
        priority if (wlen_raw < WLEN_MIN)
        begin
            wlen_clamped = WLEN_MIN;
        end
        else if (wlen_raw > WLEN_MAX)
        begin
            wlen_clamped = WLEN_MAX;
        end
        else
        begin
            wlen_clamped = wlen_raw;
        end
    end

    // Unknown indexes fall through and leave everything untouched.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length <= WLEN_RESET;
            cfg_reg.band_width    <= KW_RESET;
            cfg_reg.capital       <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LENGTH: cfg_reg.window_length <= wlen_clamped;
                CFG_BAND_WIDTH:    cfg_reg.band_width    <= cfg_data[KW_W-1:0];
                CFG_CAPITAL:       cfg_reg.capital       <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Front: ring, running sums, warm-up; only primed ticks are queued.
    rbts_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (cfg_reg.window_length),
        .restart       (restart),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .tick_time     (tick_time),
        .close_price   (close_price),
        .buy_price     (buy_price),
        .sell_price    (sell_price),
        .push          (push),
        .push_entry    (push_entry),
        .queue_full    (q_full)
    );

    // Two-entry queue lets the front run on while the back divides or waits.
    rbts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    // Back: exact band compares, position state, quantity, result register.
    rbts_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .queue_empty    (q_empty),
        .pop_entry      (pop_entry),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .event_time     (event_time),
        .event_price    (event_price),
        .trade_quantity (trade_quantity)
    );

endmodule

@@ tb/rolling_band_trade_signal_unit_test.sv @@
// ----------------------------------------------------------------------------
// rolling_band_trade_signal_unit_test
// Self-checking bench: mean-reverting tick streams under several band setups,
// every event compared against an in-bench model of the trade signal.
// ----------------------------------------------------------------------------
module rolling_band_trade_signal_unit_test;
    import rbts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // index 3 has no register behind it; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE = 60;   // covers the longest open, divider included

    typedef struct {
        logic               kind;
        logic [TIME_W-1:0]  stamp;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } trade_event_t;

    // ------------------------------------------------------------------------
    // Scoreboard: owns the signal model and the queue of pending events
    // ------------------------------------------------------------------------
    class trade_ledger;
        logic [WLEN_W-1:0]  win_len;
        logic [KW_W-1:0]    k_band;
        logic [CAP_W-1:0]   funds;
        logic [PRICE_W-1:0] closes [MAX_WINDOW];
        int unsigned        wr_ptr;
        int unsigned        filled;
        logic [63:0]        sum_c;
        logic [63:0]        sum_sq;
        bit                 long_open;
        trade_event_t       pending[$];
        int                 errors;
        int                 ticks;
        int                 opens;
        int                 closes_seen;

        function new();
            win_len = WLEN_RESET;
            k_band = KW_RESET;
            funds = '0;
            wr_ptr = 0;
            filled = 0;
            sum_c = 0;
            sum_sq = 0;
            long_open = 0;
            errors = 0;
            ticks = 0;
            opens = 0;
            closes_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] val);
            logic [WLEN_W-1:0] w;
            w = val[WLEN_W-1:0];
            case (idx)
                CFG_WINDOW_LENGTH:
                begin
                    if (w < WLEN_MIN) w = WLEN_MIN;
                    if (w > WLEN_MAX) w = WLEN_MAX;
                    win_len = w;
                    wr_ptr = 0;
                    filled = 0;
                    sum_c = 0;
                    sum_sq = 0;
                end
                CFG_BAND_WIDTH: k_band = val[KW_W-1:0];
                CFG_CAPITAL:    funds = val;
                default: ;
            endcase
        endfunction

        // Accepted tick: update the window and queue whatever event it causes.
        function void note_tick(logic [TIME_W-1:0] t, logic [PRICE_W-1:0] c,
                                logic [PRICE_W-1:0] buy, logic [PRICE_W-1:0] sell);
            logic [127:0] n;
            logic [127:0] spread;
            logic [127:0] limit;
            logic [127:0] gap;
            logic [127:0] qv;
            logic [63:0]  old;
            logic [63:0]  nc;
            bit           primed;
            trade_event_t ev;
            ticks++;
            n = win_len;
            primed = filled >= win_len;
            if (primed)
            begin
                old = closes[(wr_ptr + MAX_WINDOW - win_len) % MAX_WINDOW];
                sum_c -= old;
                sum_sq -= old * old;
            end
            else
                filled++;
            closes[wr_ptr] = c;
            sum_c += c;
            sum_sq += 64'(c) * 64'(c);
            wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
            if (!primed) return;
            // exact band test, no rounding: (4096*dev)^2 against k^2 * (N*Q - S^2)
            spread = n * 128'(sum_sq) - 128'(sum_c) * 128'(sum_c);
            limit = spread * 128'(k_band) * 128'(k_band);
            nc = 64'(win_len) * 64'(c);
            if (!long_open && sum_c > nc)
            begin
                gap = 128'(sum_c - nc) << 12;
                if (gap * gap > limit)
                begin
                    qv = 0;
                    if (buy != 0)
                    begin
                        qv = 128'(funds) / (128'(20) * 128'(buy));
                        if (qv > 128'(32'hFFFF_FFFF)) qv = 32'hFFFF_FFFF;
                    end
                    long_open = 1;
                    ev.kind = EVT_OPEN;
                    ev.stamp = t;
                    ev.price = buy;
                    ev.qty = qv[QTY_W-1:0];
                    pending = {pending, ev};
                end
            end
            else if (long_open && nc > sum_c)
            begin
                gap = 128'(nc - sum_c) << 12;
                if (gap * gap > limit)
                begin
                    long_open = 0;
                    ev.kind = EVT_CLOSE;
                    ev.stamp = t;
                    ev.price = sell;
                    ev.qty = '0;
                    pending = {pending, ev};
                end
            end
        endfunction

        function void check_event(trade_event_t got);
            trade_event_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected event kind=%0d time=%0h", got.kind, got.stamp);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind == EVT_OPEN) opens++; else closes_seen++;
            if (got.kind !== want.kind)
            begin
                $error("event_kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.stamp !== want.stamp)
            begin
                $error("event_time: expected %0h, got %0h", want.stamp, got.stamp);
                errors++;
            end
            if (got.price !== want.price)
            begin
                $error("event_price: expected %0d, got %0d", want.price, got.price);
                errors++;
            end
            if (got.qty !== want.qty)
            begin
                $error("trade_quantity: expected %0d, got %0d", want.qty, got.qty);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CAP_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [TIME_W-1:0]    tick_time;
    logic [PRICE_W-1:0]   close_price;
    logic [PRICE_W-1:0]   buy_price;
    logic [PRICE_W-1:0]   sell_price;
    logic                 out_valid;
    logic                 out_stall;
    logic                 event_kind;
    logic [TIME_W-1:0]    event_time;
    logic [PRICE_W-1:0]   event_price;
    logic [QTY_W-1:0]     trade_quantity;

    trade_ledger ledger = new();
    int idle_mode;     // 0 none, 1 sender gaps, 2 receiver stalls, 3 both light
    int quiet_cycles;

    rolling_band_trade_signal_unit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver back-pressure, changed on the falling edge only.
    always @(negedge clk)
    begin
        case (idle_mode)
            2: out_stall <= ($urandom_range(0, 99) < 75);
            3: out_stall <= ($urandom_range(0, 99) < 16);
            default: out_stall <= 1'b0;
        endcase
    end

    // Monitor: every handshake at the rising edge feeds the scoreboard.
    always @(posedge clk)
    begin
        trade_event_t got;
        bit           moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                ledger.write_reg(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (in_valid && !in_stall)
            begin
                ledger.note_tick(tick_time, close_price, buy_price, sell_price);
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                got.kind = event_kind;
                got.stamp = event_time;
                got.price = event_price;
                got.qty = trade_quantity;
                ledger.check_event(got);
                moved = 1'b1;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("rolling_band_trade_signal_unit_test: errors");
            $finish;
        end
    end

    // All tasks start and end just after a falling edge.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(logic [PRICE_W-1:0] c, logic [PRICE_W-1:0] buy,
                             logic [PRICE_W-1:0] sell);
        if ((idle_mode == 1 && $urandom_range(0, 99) < 75) ||
            (idle_mode == 3 && $urandom_range(0, 99) < 16))
        begin
            in_valid <= 1'b0;
            do @(negedge clk);
            while ((idle_mode == 1 && $urandom_range(0, 99) < 75) ||
                   (idle_mode == 3 && $urandom_range(0, 99) < 16));
        end
        tick_time <= 48'({$urandom, $urandom});
        close_price <= c;
        buy_price <= buy;
        sell_price <= sell;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Stop sending, let every expected event arrive, then let the pipe settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (ledger.pending.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        logic [PRICE_W-1:0] base;
        logic [PRICE_W-1:0] c;
        int                 swing;
        int                 level;
        logic [WLEN_W-1:0]  win_pick [8] = '{0, 1, 2, 3, 64, 127, 20, 9};
        logic [KW_W-1:0]    k_pick;
        logic [CAP_W-1:0]   cap_pick;

        idle_mode = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WINDOW_LENGTH;
        cfg_data = '0;
        in_valid = 1'b0;
        tick_time = '0;
        close_price = '0;
        buy_price = '0;
        sell_price = '0;
        out_stall = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: a few warm-up ticks at reset settings (capital 0), then
        // smallest window, zero band, full capital.
        send_tick(24'd500, 24'd501, 24'd499);
        send_tick(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        drain();
        write_cfg(CFG_WINDOW_LENGTH, 40'd2);
        write_cfg(CFG_BAND_WIDTH, 40'd0);
        write_cfg(CFG_CAPITAL, 40'hFF_FFFF_FFFF);
        write_cfg(CFG_NONE, 40'hFF_FFFF_FFFF);
        send_tick(24'd100, 24'd1, 24'd1);          // warm-up, no event
        send_tick(24'd100, 24'd1, 24'd1);
        send_tick(24'd50, 24'd0, 24'd7);           // open at zero ask: quantity 0
        send_tick(24'd200, 24'd3, 24'hFFFFFF);     // close at top bid
        send_tick(24'd10, 24'd1, 24'd2);           // open, quantity saturates
        send_tick(24'hFFFFFF, 24'd5, 24'd0);       // close, zero bid
        send_tick(24'd0, 24'hFFFFFF, 24'd9);       // open at top ask
        send_tick(24'hFFFFFF, 24'h800000, 24'h7FFFFF);
        send_tick(24'h5A5A5A, 24'hA5A5A5, 24'h5A5A5A);
        send_tick(24'hA5A5A5, 24'h5A5A5A, 24'hA5A5A5);
        send_tick(24'd0, 24'd20, 24'd20);
        drain();
        write_cfg(CFG_BAND_WIDTH, 40'd65535);      // widest band: rare events
        send_tick(24'hFFFFFF, 24'd1, 24'd1);
        send_tick(24'd0, 24'd1, 24'd1);
        send_tick(24'hFFFFFF, 24'd1, 24'd1);

        // Random phases: mean-reverting walks around a random level.
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            idle_mode = 0;
            k_pick = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 9000));
            if (ph == 5) k_pick = 16'hFFFF;
            case (ph % 3)
                0: cap_pick = 40'hFF_FFFF_FFFF;
                1: cap_pick = 40'({$urandom, $urandom});
                default: cap_pick = 40'($urandom_range(0, 100000));
            endcase
            write_cfg(CFG_CAPITAL, cap_pick);
            write_cfg(CFG_BAND_WIDTH, k_pick);
            write_cfg(CFG_WINDOW_LENGTH, {$urandom, 1'b0, win_pick[ph]} & 40'hFF_FFFF_FF7F
                      | 40'(win_pick[ph]));
            if (ph % 4 == 3) write_cfg(CFG_NONE, 40'({$urandom, $urandom}));
            idle_mode = ph % 4;
            base = 24'($urandom);
            swing = $urandom_range(1, 1 << $urandom_range(2, 20));
            level = base;
            for (int i = 0; i < 250; i++)
            begin
                // pull toward the base, add noise, now and then a spike
                level = level + (int'(base) - level) / 4
                        + int'($urandom_range(0, 2 * swing)) - swing;
                if ($urandom_range(0, 19) == 0)
                    level = level + ($urandom_range(0, 1) ? 8 * swing : -8 * swing);
                if ($urandom_range(0, 99) == 0)
                    level = $urandom_range(0, 24'hFFFFFF);
                if (level < 0) level = 0;
                if (level > 24'hFFFFFF) level = 24'hFFFFFF;
                c = 24'(level);
                send_tick(c, ($urandom_range(0, 15) == 0) ? 24'($urandom) : c + 24'd1,
                          ($urandom_range(0, 15) == 0) ? 24'($urandom) : c - 24'd1);
            end
        end
        drain();

        $display("covered %0d ticks over directed and 8 random setups, %0d opens and %0d closes checked",
                 ledger.ticks, ledger.opens, ledger.closes_seen);
        if (ledger.errors == 0)
            $display("rolling_band_trade_signal_unit_test: clean");
        else
            $display("rolling_band_trade_signal_unit_test: errors");
        $finish;
    end

endmodule
